[hw/rtl/grpe_pkg.sv]
// Shared types, register codes and constants of the glyph row pixel expander.
package grpe_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned MAX_GLYPH_WIDTH_DEF = 32;
  localparam int unsigned STORE_DEPTH_DEF     = 32768;

  // Codes at or above this are never looked up
  localparam int unsigned MAX_GLYPHS  = 256;
  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned BYTE_W = 8;

  // Stand-in glyph for codes beyond the font: '?'
  localparam logic [7:0] SUBST_CODE = 8'h3F;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [2:0] {
    REG_LINE_STRIDE  = 3'd0,
    REG_GLYPH_WIDTH  = 3'd1,
    REG_GLYPH_HEIGHT = 3'd2,
    REG_GLYPH_COUNT  = 3'd3,
    REG_GLYPH_BYTES  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [13:0] line_stride;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [8:0]  glyph_count;
    logic [7:0]  glyph_bytes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    line_stride:  14'd1024,
    glyph_width:  6'd8,
    glyph_height: 6'd16,
    glyph_count:  9'd256,
    glyph_bytes:  8'd16
  };

  // One queued operation: a font byte load or a classified glyph row draw
  typedef struct packed {
    logic        op;         // OP_LOAD or OP_DRAW
    logic [16:0] addr;       // load index, or first store byte of the row
    logic [7:0]  data;       // load byte
    logic [5:0]  width;      // saturated glyph width, nonzero for draws
    logic [2:0]  row_bytes;  // store bytes per glyph row
    logic [26:0] line_off;   // (origin_y + row) * line_stride, mod 2^27
    logic [12:0] origin_x;
    logic [31:0] fore_colour;
    logic [31:0] back_colour;
  } q_entry_t;

endpackage

[hw/rtl/grpe_if.sv]
// Handshake channels of the glyph row pixel expander: items in, pixels out, config.
interface grpe_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [14:0] store_index;
  logic [7:0]  store_value;
  logic [7:0]  char_code;
  logic [12:0] origin_x;
  logic [12:0] origin_y;
  logic [4:0]  row_in_glyph;
  logic [31:0] fore_colour;
  logic [31:0] back_colour;

  modport source (
    output valid, operation, store_index, store_value, char_code, origin_x, origin_y,
           row_in_glyph, fore_colour, back_colour,
    input  ready
  );
  modport sink (
    input  valid, operation, store_index, store_value, char_code, origin_x, origin_y,
           row_in_glyph, fore_colour, back_colour,
    output ready
  );
endinterface

interface grpe_out_if;
  logic        valid;
  logic        ready;
  logic [26:0] pixel_offset;
  logic [31:0] pixel_colour;
  logic        last_pixel;

  modport source (output valid, pixel_offset, pixel_colour, last_pixel, input ready);
  modport sink (input valid, pixel_offset, pixel_colour, last_pixel, output ready);
endinterface

interface grpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/grpe_ram.sv]
// Generic single-clock RAM, one write and one read port, registered read data.
module grpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/grpe_fifo.sv]
// Short queue of classified operations between the front and the back.
module grpe_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  grpe_pkg::q_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output grpe_pkg::q_entry_t head_o
);
  import grpe_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[hw/rtl/grpe_front.sv]
// Front end: takes items, substitutes codes, drops empty draws, precomputes addresses.
module grpe_front #(
  parameter int unsigned MAX_GLYPH_WIDTH = grpe_pkg::MAX_GLYPH_WIDTH_DEF
) (
  input  grpe_pkg::cfg_t     cfg_i,
  grpe_in_if.sink            item_i,
  input  logic               full_i,
  output logic               push_o,
  output grpe_pkg::q_entry_t entry_o
);
  import grpe_pkg::*;

  logic [7:0]  code_sub;
  logic [5:0]  width_sat;
  logic [2:0]  row_bytes;
  logic [15:0] glyph_base;
  logic [7:0]  row_base;
  logic [13:0] line_y;
  logic [27:0] line_prod;
  logic        keep;

  always_comb begin
    // unsigned code; anything beyond the font draws the stand-in glyph
    code_sub = item_i.char_code;
    if (({1'b0, item_i.char_code} >= cfg_i.glyph_count) ||
        ({1'b0, item_i.char_code} >= 9'(MAX_GLYPHS))) begin
      code_sub = SUBST_CODE;
    end

    width_sat = (cfg_i.glyph_width > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH)
                                                           : cfg_i.glyph_width;
    row_bytes = 3'((width_sat + 6'd7) >> 3);

    glyph_base = code_sub * cfg_i.glyph_bytes;
    row_base   = item_i.row_in_glyph * row_bytes;

    line_y    = 14'(item_i.origin_y) + 14'(item_i.row_in_glyph);
    line_prod = line_y * cfg_i.line_stride;

    keep = (item_i.operation == OP_LOAD) ||
           ((code_sub != '0) &&
            ({1'b0, item_i.row_in_glyph} < cfg_i.glyph_height) &&
            (width_sat != '0));
  end

  always_comb begin
    entry_o.op          = item_i.operation;
    entry_o.addr        = (item_i.operation == OP_LOAD) ? 17'(item_i.store_index)
                                                        : 17'(glyph_base) + 17'(row_base);
    entry_o.data        = item_i.store_value;
    entry_o.width       = width_sat;
    entry_o.row_bytes   = row_bytes;
    entry_o.line_off    = line_prod[26:0];
    entry_o.origin_x    = item_i.origin_x;
    entry_o.fore_colour = item_i.fore_colour;
    entry_o.back_colour = item_i.back_colour;
  end

  // dropped draws are still taken, they just never reach the queue
  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i && keep;

endmodule

[hw/rtl/grpe_back.sv]
// Back end: applies loads, fetches a glyph row, emits one pixel per cycle unless stalled.
module grpe_back #(
  parameter int unsigned MAX_GLYPH_WIDTH = grpe_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned STORE_DEPTH     = grpe_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  grpe_pkg::q_entry_t             head_i,
  output logic                           pop_o,
  output logic                           ram_we_o,
  output logic [$clog2(STORE_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                     ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(STORE_DEPTH)-1:0] ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  grpe_out_if.source                     pix_o
);
  import grpe_pkg::*;

  localparam int unsigned AW     = $clog2(STORE_DEPTH);
  localparam int unsigned RB_MAX = (MAX_GLYPH_WIDTH + BYTE_W - 1) / BYTE_W;
  localparam int unsigned BUF_W  = RB_MAX * BYTE_W;
  localparam int unsigned CW     = $clog2(RB_MAX + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [16:0]      base_q, base_d;
  logic [2:0]       rb_q, rb_d;
  logic [5:0]       width_q, width_d;
  logic [31:0]      fg_q, fg_d;
  logic [31:0]      bg_q, bg_d;
  logic [26:0]      off_q, off_d;
  logic [CW-1:0]    req_q, req_d;
  logic [CW-1:0]    rcv_q, rcv_d;
  logic             rd_vld_q;
  logic [BUF_W-1:0] buf_q, buf_d;
  logic [5:0]       col_q, col_d;

  logic             ovld_q, ovld_d;
  logic [26:0]      ooff_q, ooff_d;
  logic [31:0]      ocol_q, ocol_d;
  logic             olast_q, olast_d;

  logic             out_free;
  logic             emit;
  logic             pix_last;
  logic [16:0]      rd_addr;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign ram_we_o    = pop_o && (head_i.op == OP_LOAD);
  assign ram_waddr_o = head_i.addr[AW-1:0];
  assign ram_wdata_o = head_i.data;

  assign rd_addr     = base_q + 17'(req_q);
  assign ram_re_o    = (state_q == ST_FETCH) && (3'(req_q) < rb_q);
  assign ram_raddr_o = rd_addr[AW-1:0];

  assign out_free = !ovld_q || pix_o.ready;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign pix_last = (col_q == width_q - 6'd1);

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    rb_d    = rb_q;
    width_d = width_q;
    fg_d    = fg_q;
    bg_d    = bg_q;
    off_d   = off_q;
    req_d   = req_q;
    rcv_d   = rcv_q;
    buf_d   = buf_q;
    col_d   = col_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_o && (head_i.op == OP_DRAW)) begin
          base_d  = head_i.addr;
          rb_d    = head_i.row_bytes;
          width_d = head_i.width;
          fg_d    = head_i.fore_colour;
          bg_d    = head_i.back_colour;
          off_d   = head_i.line_off + 27'(head_i.origin_x);
          req_d   = '0;
          rcv_d   = '0;
          col_d   = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (ram_re_o) begin
          req_d = req_q + CW'(1);
        end
        if (rd_vld_q) begin
          // byte k of the row lands k bytes below the top, so column 0 is the MSB
          for (int k = 0; k < RB_MAX; k++) begin
            if (rcv_q == CW'(k)) begin
              buf_d[BUF_W - 1 - k * BYTE_W -: BYTE_W] = ram_rdata_i;
            end
          end
          rcv_d = rcv_q + CW'(1);
          if (3'(rcv_q) == rb_q - 3'd1) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit) begin
          buf_d = buf_q << 1;
          off_d = off_q + 27'd1;
          col_d = col_q + 6'd1;
          if (pix_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_d  = ovld_q;
    ooff_d  = ooff_q;
    ocol_d  = ocol_q;
    olast_d = olast_q;
    if (out_free) begin
      ovld_d = emit;
      if (emit) begin
        ooff_d  = off_q;
        ocol_d  = buf_q[BUF_W-1] ? fg_q : bg_q;
        olast_d = pix_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      req_q    <= '0;
      rcv_q    <= '0;
      rd_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      req_q    <= req_d;
      rcv_q    <= rcv_d;
      rd_vld_q <= ram_re_o;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    rb_q    <= rb_d;
    width_q <= width_d;
    fg_q    <= fg_d;
    bg_q    <= bg_d;
    off_q   <= off_d;
    buf_q   <= buf_d;
    col_q   <= col_d;
    ooff_q  <= ooff_d;
    ocol_q  <= ocol_d;
    olast_q <= olast_d;
  end

  assign pix_o.valid        = ovld_q;
  assign pix_o.pixel_offset = ooff_q;
  assign pix_o.pixel_colour = ocol_q;
  assign pix_o.last_pixel   = olast_q;

`ifndef SYNTHESIS
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("store written and read in the same cycle");

  a_rdata_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_FETCH))
    else $error("store read data returned outside row fetch");

  a_rcv_behind_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (rcv_q <= req_q))
    else $error("more row bytes received than requested");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && pix_last) |=> (state_q == ST_IDLE) && ovld_q && olast_q)
    else $error("last pixel did not close the row");
`endif

endmodule

[hw/rtl/glyph_row_pixel_expander.sv]
// Top level of the glyph row pixel expander: config registers, front, queue, back, store.
// Draw path: a taken draw item passes through the queue; the idle back end pops it, reads
//   rb = ceil(min(glyph_width, MAX_GLYPH_WIDTH)/8) row bytes, then registers pixels on out_o.
// Throughput: per draw the back end makes rb store reads, then w pixels, one per cycle while
//   out_o is ready, popping only when idle; the queue holds 2 items; empty draws skip it.
// Reset: control state and config registers return to reset values; the store keeps unknowns.
module glyph_row_pixel_expander #(
  parameter int unsigned MAX_GLYPH_WIDTH = grpe_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned STORE_DEPTH     = grpe_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  grpe_cfg_if.sink    cfg_i,
  grpe_in_if.sink     in_i,
  grpe_out_if.source  out_o
);
  import grpe_pkg::*;

  // Store indices wrap by truncation: STORE_DEPTH is a power of two.
  localparam int unsigned AW = $clog2(STORE_DEPTH);

  cfg_t          cfg_q, cfg_d;

  q_entry_t      push_entry;
  q_entry_t      head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Config writes are always taken; unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_LINE_STRIDE:  cfg_d.line_stride  = cfg_i.data;
        REG_GLYPH_WIDTH:  cfg_d.glyph_width  = cfg_i.data[5:0];
        REG_GLYPH_HEIGHT: cfg_d.glyph_height = cfg_i.data[5:0];
        REG_GLYPH_COUNT:  cfg_d.glyph_count  = cfg_i.data[8:0];
        REG_GLYPH_BYTES:  cfg_d.glyph_bytes  = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify and precompute. Loads go through the queue too, so they
  // reach the store in order with the draws around them.
  grpe_front #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_front (
    .cfg_i   (cfg_q),
    .item_i  (in_i),
    .full_i  (q_full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  grpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // Back: store writes, row fetch, pixel serializer with output register.
  grpe_back #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .STORE_DEPTH     (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .pix_o       (out_o)
  );

  // Glyph store, one byte per entry.
  grpe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[test/tb_glyph_row_pixel_expander.sv]
// Testbench for the glyph row pixel expander: self-checking random and directed run.
`timescale 1ns / 1ps

module tb_glyph_row_pixel_expander;
  import grpe_pkg::*;

  localparam int unsigned DEPTH       = STORE_DEPTH_DEF;
  localparam int unsigned MAX_GLYPH_W = MAX_GLYPH_WIDTH_DEF;
  // Idle cycles allowed after the last pixel before touching config: covers loads
  // still sitting in the queue behind the final draw.
  localparam int DRAIN_CYCLES = 48;
  localparam int TAIL_CYCLES  = 64;
  // Long receiver hold-off, in cycles
  localparam int HOLD_CYCLES  = 300;
  // Cycles with no handshake on any channel before the run is declared hung.
  // Longest legitimate quiet stretch is the hold-off above plus a drain.
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic        operation;
    logic [14:0] store_index;
    logic [7:0]  store_value;
    logic [7:0]  char_code;
    logic [12:0] origin_x;
    logic [12:0] origin_y;
    logic [4:0]  row_in_glyph;
    logic [31:0] fore_colour;
    logic [31:0] back_colour;
  } glyph_item_t;

  typedef struct packed {
    logic [26:0] pix_offset;
    logic [31:0] pix_colour;
    logic        last_pix;
  } pixel_t;

  // Shadow of the font store and registers; expands each draw into the pixels due
  class glyph_row_tracker;
    cfg_t       regs;
    logic [7:0] font [DEPTH];
    bit         loaded [DEPTH];
    pixel_t     pixels_due [$];
    int         errors;

    function new();
      regs   = CFG_RESET;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [13:0] d);
      case (r)
        REG_LINE_STRIDE:  regs.line_stride  = d;
        REG_GLYPH_WIDTH:  regs.glyph_width  = d[5:0];
        REG_GLYPH_HEIGHT: regs.glyph_height = d[5:0];
        REG_GLYPH_COUNT:  regs.glyph_count  = d[8:0];
        REG_GLYPH_BYTES:  regs.glyph_bytes  = d[7:0];
        default: ;
      endcase
    endfunction

    // First store byte (unwrapped) and pixel count of a draw; w = 0 means no pixels
    function void row_span(input glyph_item_t it, output int unsigned first,
                           output int unsigned w);
      int unsigned code;
      code  = it.char_code;
      first = 0;
      w     = 0;
      if (code >= regs.glyph_count || code >= MAX_GLYPHS) code = SUBST_CODE;
      if (code == 0 || it.row_in_glyph >= regs.glyph_height) return;
      w     = (regs.glyph_width > MAX_GLYPH_W) ? MAX_GLYPH_W : regs.glyph_width;
      first = code * regs.glyph_bytes + it.row_in_glyph * ((w + 7) / 8);
    endfunction

    function void take_item(glyph_item_t it);
      int unsigned     first, w;
      longint unsigned off;
      logic [7:0]      b;
      pixel_t          px;
      if (it.operation == OP_LOAD) begin
        font[it.store_index % DEPTH]   = it.store_value;
        loaded[it.store_index % DEPTH] = 1'b1;
        return;
      end
      row_span(it, first, w);
      for (int unsigned col = 0; col < w; col++) begin
        b   = font[(first + col / 8) % DEPTH];
        off = it.origin_y;
        off = (off + it.row_in_glyph) * regs.line_stride + it.origin_x + col;
        px.pix_offset = off[26:0];
        px.pix_colour = b[7 - col % 8] ? it.fore_colour : it.back_colour;
        px.last_pix   = (col + 1 == w);
        pixels_due.push_back(px);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("unexpected pixel, offset %0d colour %h", got.pix_offset,
                         got.pix_colour));
        return;
      end
      want = pixels_due.pop_front();
      if (got.pix_offset !== want.pix_offset)
        report($sformatf("pixel_offset got %0d want %0d", got.pix_offset, want.pix_offset));
      if (got.pix_colour !== want.pix_colour)
        report($sformatf("pixel_colour got %h want %h at offset %0d", got.pix_colour,
                         want.pix_colour, want.pix_offset));
      if (got.last_pix !== want.last_pix)
        report($sformatf("last_pixel got %b want %b at offset %0d", got.last_pix,
                         want.last_pix, want.pix_offset));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  grpe_cfg_if cfg_if ();
  grpe_in_if  in_if ();
  grpe_out_if out_if ();

  glyph_row_pixel_expander dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  glyph_row_tracker tracker;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   phase_items    = 0;
  int   quiet_cycles   = 0;
  logic hold_on        = 1'b0;
  event hold_ev;

  always #6 clk_i = ~clk_i;

  // Pixel sink: check what was taken at this edge, then pick ready for the next one
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      tracker.check_pixel(pixel_t'{out_if.pixel_offset, out_if.pixel_colour,
                                   out_if.last_pixel});
    out_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Hang detector: any handshake on any channel resets the count
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic glyph_item_t load_item(int unsigned idx, logic [7:0] val);
    glyph_item_t it;
    // unused draw fields carry noise so every input bit toggles
    it             = 127'({$urandom, $urandom, $urandom, $urandom});
    it.operation   = OP_LOAD;
    it.store_index = idx[14:0];
    it.store_value = val;
    return it;
  endfunction

  function automatic glyph_item_t draw_item(logic [7:0] code, logic [12:0] x, logic [12:0] y,
                                            logic [4:0] row, logic [31:0] fg,
                                            logic [31:0] bg);
    glyph_item_t it;
    it              = 127'({$urandom, $urandom, $urandom, $urandom});
    it.operation    = OP_DRAW;
    it.char_code    = code;
    it.origin_x     = x;
    it.origin_y     = y;
    it.row_in_glyph = row;
    it.fore_colour  = fg;
    it.back_colour  = bg;
    return it;
  endfunction

  function automatic logic [12:0] pick_coord();
    case ($urandom_range(19))
      0:       return '1;
      1:       return '0;
      default: return 13'($urandom);
    endcase
  endfunction

  task automatic send(glyph_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= it.operation;
    in_if.store_index  <= it.store_index;
    in_if.store_value  <= it.store_value;
    in_if.char_code    <= it.char_code;
    in_if.origin_x     <= it.origin_x;
    in_if.origin_y     <= it.origin_y;
    in_if.row_in_glyph <= it.row_in_glyph;
    in_if.fore_colour  <= it.fore_colour;
    in_if.back_colour  <= it.back_colour;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_item(it);
    phase_items++;
  endtask

  // A draw never reads an unloaded byte: missing glyph bytes get loaded first
  task automatic draw(glyph_item_t it);
    int unsigned first, w;
    tracker.row_span(it, first, w);
    for (int unsigned i = 0; i < (w + 7) / 8; i++)
      if (!tracker.loaded[(first + i) % DEPTH])
        send(load_item((first + i) % DEPTH, 8'($urandom)));
    send(it);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [13:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_reg(r, d);
  endtask

  // Registers change only once the pipeline has emptied
  task automatic program_regs(cfg_t c);
    while (tracker.pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_LINE_STRIDE, c.line_stride);
    write_reg(REG_GLYPH_WIDTH, 14'(c.glyph_width));
    write_reg(REG_GLYPH_HEIGHT, 14'(c.glyph_height));
    write_reg(REG_GLYPH_COUNT, 14'(c.glyph_count));
    write_reg(REG_GLYPH_BYTES, 14'(c.glyph_bytes));
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly draws from a small set of glyphs (so rows get reused), plus stray loads,
  // out-of-font codes, code zero and rows past the glyph height.
  task automatic run_phase(cfg_t c, int send_pct, int recv_pct, int n, bit hold_off,
                           bit pause);
    logic [7:0] hot [6];
    logic [7:0] code;
    logic [4:0] row;
    int         h, top, roll;
    program_regs(c);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    top = (c.glyph_count > MAX_GLYPHS) ? MAX_GLYPHS - 1 : int'(c.glyph_count) - 1;
    foreach (hot[i])
      hot[i] = (top >= 1) ? 8'($urandom_range(top, 1)) : 8'($urandom_range(255));
    h = (c.glyph_height > 6'd32) ? 32 : int'(c.glyph_height);
    phase_items = 0;
    // corner cell: highest code, last row, far bottom-right origin
    draw(draw_item(8'd255, '1, '1, (h > 0) ? 5'(h - 1) : 5'd31, '1, '0));
    while (phase_items < n) begin
      if (hold_off && phase_items >= 4) begin
        -> hold_ev;
        hold_off = 1'b0;
      end
      if (pause && phase_items >= n / 2) begin
        // sender waits for every pending pixel
        pause = 1'b0;
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (tracker.pixels_due.size() != 0);
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
        send(load_item($urandom_range(DEPTH - 1), 8'($urandom)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 60)      code = hot[$urandom_range(5)];
        else if (roll < 65) code = '0;
        else                code = 8'($urandom_range(255));
        if (h > 0 && $urandom_range(99) < 85) row = 5'($urandom_range(h - 1));
        else                                  row = 5'($urandom_range(31));
        draw(draw_item(code, pick_coord(), pick_coord(), row, $urandom, $urandom));
      end
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    cfg_t mid;
    tracker = new();
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_LOAD;
    in_if.store_index  <= '0;
    in_if.store_value  <= '0;
    in_if.char_code    <= '0;
    in_if.origin_x     <= '0;
    in_if.origin_y     <= '0;
    in_if.row_in_glyph <= '0;
    in_if.fore_colour  <= '0;
    in_if.back_colour  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_LINE_STRIDE;
    cfg_if.data        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset config: 8x16 font, 16 bytes per glyph, stride 1024
    send(load_item(0, 8'h00));
    send(load_item(DEPTH - 1, 8'hFF));
    send(load_item(DEPTH - 1, 8'hA5));            // overwrite same byte
    send(load_item(65 * 16 + 0, 8'h81));
    send(load_item(65 * 16 + 1, 8'hFF));
    send(load_item(65 * 16 + 2, 8'h00));
    draw(draw_item(8'd65, '0, '0, 5'd0, '0, '1));
    draw(draw_item(8'd65, 13'd17, 13'd3, 5'd1, 32'h1234_5678, 32'h9ABC_DEF0));
    draw(draw_item(8'd65, 13'd100, 13'd200, 5'd2, '1, '0));
    draw(draw_item(8'd255, '1, '1, 5'd15, '1, '0));
    draw(draw_item(8'd0, 13'd8, 13'd8, 5'd0, '1, '0));       // code zero: nothing
    draw(draw_item(8'd65, 13'd8, 13'd8, 5'd16, '1, '0));     // row past height
    draw(draw_item(8'd65, 13'd8, 13'd8, 5'd31, '1, '0));
    draw(draw_item(SUBST_CODE, 13'd40, 13'd40, 5'd7, $urandom, $urandom));
    draw(draw_item(8'd128, 13'd4095, 13'd100, 5'd3, $urandom, $urandom));
    in_if.valid <= 1'b0;

    // Large extremes: widest glyph, offset wrap, top code reaching the last store byte
    run_phase(cfg_t'{line_stride: 14'd16383, glyph_width: 6'd32, glyph_height: 6'd32,
                     glyph_count: 9'd256, glyph_bytes: 8'd128}, 0, 0, 45, 1'b1, 1'b0);
    // Smallest: one-pixel glyphs, one-glyph font so nearly every code becomes '?'
    run_phase(cfg_t'{line_stride: 14'd1, glyph_width: 6'd1, glyph_height: 6'd1,
                     glyph_count: 9'd1, glyph_bytes: 8'd1}, 48, 0, 35, 1'b0, 1'b0);
    mid = cfg_t'{line_stride: 14'd640, glyph_width: 6'd12, glyph_height: 6'd8,
                 glyph_count: 9'd100, glyph_bytes: 8'd24};
    mid.line_stride = 14'($urandom_range(8192, 1));
    run_phase(mid, 0, 48, 45, 1'b0, 1'b1);
    // Register fields at their all-ones limits: width saturates, store index wraps
    run_phase(cfg_t'{line_stride: 14'h3FFF, glyph_width: 6'd63, glyph_height: 6'd63,
                     glyph_count: 9'd511, glyph_bytes: 8'd255}, 22, 22, 45, 1'b0, 1'b0);
    // Empty font and zero stride: every code maps to '?', offsets are x+column
    run_phase(cfg_t'{line_stride: 14'd0, glyph_width: 6'd3, glyph_height: 6'd5,
                     glyph_count: 9'd0, glyph_bytes: 8'd0}, 22, 22, 15, 1'b0, 1'b0);
    run_phase(cfg_t'{line_stride: 14'd8192, glyph_width: 6'd20, glyph_height: 6'd12,
                     glyph_count: 9'd64, glyph_bytes: 8'd40}, 0, 48, 35, 1'b0, 1'b0);
    // Zero width: draws are swallowed
    run_phase(cfg_t'{line_stride: 14'd5, glyph_width: 6'd0, glyph_height: 6'd32,
                     glyph_count: 9'd256, glyph_bytes: 8'd16}, 0, 0, 10, 1'b0, 1'b0);

    while (tracker.pixels_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pixels_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/grpe_pkg.sv
hw/rtl/grpe_if.sv
hw/rtl/grpe_ram.sv
hw/rtl/grpe_fifo.sv
hw/rtl/grpe_front.sv
hw/rtl/grpe_back.sv
hw/rtl/glyph_row_pixel_expander.sv
test/tb_glyph_row_pixel_expander.sv
